>>> rtl/dhr_pkg.sv
// dhr_pkg: types and constants shared by the decimating history ring modules.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package dhr_pkg;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_READ_ALL   = 2'd1;
    localparam logic [1:0] OP_READ_SINCE = 2'd2;
    localparam logic [1:0] OP_CLEAR      = 2'd3;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_INTERVAL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AVERAGE_MODE    = 1'd1;

    localparam logic [31:0] RESET_INTERVAL_US = 32'd1000000;
    localparam logic [15:0] COUNT_MAX         = 16'd65535;

    localparam int ACC_W      = 48;
    localparam int DIV_STEPS  = ACC_W;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int CQ_PTR_W        = $clog2(CMD_QUEUE_DEPTH);
    localparam int CQ_CNT_W        = $clog2(CMD_QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] sample_value;
        logic [31:0]        now_us;
        logic [31:0]        seen_sequence;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               has_data;
        logic               is_last;
        logic [31:0]        current_sequence;
        logic [6:0]         stored_count;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_READ_ALL,
        CMD_READ_SINCE,
        CMD_CLEAR
    } cmd_kind_t;

    // Command as classified by the front end, with the configuration in force
    // at the time the item was taken.
    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [31:0] sample_value;
        logic [31:0]        now_us;
        logic [31:0]        seen_sequence;
        logic [31:0]        interval_us;
        logic               average_mode;
    } cmd_t;

    typedef struct packed {
        logic                   start;
        logic signed [ACC_W-1:0] dividend;
        logic [15:0]            divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_TICK,
        BK_DIV,
        BK_RD_REQ,
        BK_RD_PUSH,
        BK_EMPTY
    } back_state_t;

endpackage

>>> rtl/dhr_front.sv
// dhr_front: input stage; holds the configuration registers, classifies each
// input item and tags it with the current configuration. Uses dhr_pkg.
`timescale 1ns / 1ps

module dhr_front
    import dhr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_payload,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   cmd_valid,
    input  logic                   cmd_ready,
    output cmd_t                   cmd
);

    logic [31:0] interval_reg;
    logic        mode_reg;
    logic        hold_valid_reg;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    logic        accept;

    assign s_ready   = !hold_valid_reg || cmd_ready;
    assign accept    = s_valid && s_ready;
    assign cmd_valid = hold_valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= RESET_INTERVAL_US;
            mode_reg     <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SAMPLE_INTERVAL: interval_reg <= cfg_data[31:0];
                CFG_AVERAGE_MODE:    mode_reg     <= cfg_data[0];
            endcase
        end
    end

    always_comb begin
        cmd_next.sample_value  = s_payload.sample_value;
        cmd_next.now_us        = s_payload.now_us;
        cmd_next.seen_sequence = s_payload.seen_sequence;
        cmd_next.interval_us   = interval_reg;
        cmd_next.average_mode  = mode_reg;
        unique case (s_payload.opcode)
            OP_TICK:       cmd_next.kind = CMD_TICK;
            OP_READ_ALL:   cmd_next.kind = CMD_READ_ALL;
            OP_READ_SINCE: cmd_next.kind = CMD_READ_SINCE;
            OP_CLEAR:      cmd_next.kind = CMD_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (accept) begin
            hold_valid_reg <= 1'b1;
        end else if (cmd_ready) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

>>> rtl/dhr_cmd_fifo.sv
// dhr_cmd_fifo: short command queue between the front end and the back end.
// Uses cmd_t and the queue depth from dhr_pkg.
`timescale 1ns / 1ps

module dhr_cmd_fifo
    import dhr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t                entry_mem [CMD_QUEUE_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg;
    logic [CQ_PTR_W-1:0] rd_ptr_reg;
    logic [CQ_CNT_W-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != CQ_CNT_W'(CMD_QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == CQ_PTR_W'(CMD_QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == CQ_PTR_W'(CMD_QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/dhr_divider.sv
// dhr_divider: restoring divider, one quotient bit per cycle, for the average.
// Signed 48-bit dividend, unsigned 16-bit divisor, truncation toward zero.
// Uses dhr_pkg.
`timescale 1ns / 1ps

module dhr_divider
    import dhr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [15:0]           rem_reg;
    logic [ACC_W-1:0]      quo_reg;
    logic [15:0]           divisor_reg;
    logic                  neg_reg;

    logic [16:0]           rem_shift;
    logic                  fits;
    logic [16:0]           rem_diff;
    logic [ACC_W-1:0]      magnitude;
    logic                  last_step;

    assign magnitude = req.dividend[ACC_W-1] ? ACC_W'(-req.dividend) : ACC_W'(req.dividend);
    assign rem_shift = {rem_reg, quo_reg[ACC_W-1]};
    assign fits      = rem_shift >= {1'b0, divisor_reg};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign last_step = step_reg == DIV_STEP_W'(DIV_STEPS - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && !req.start && last_step;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (last_step) begin
                    busy_reg <= 1'b0;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg     <= '0;
            quo_reg     <= magnitude;
            divisor_reg <= req.divisor;
            neg_reg     <= req.dividend[ACC_W-1];
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_diff[15:0] : rem_shift[15:0];
            quo_reg <= {quo_reg[ACC_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(quo_reg[31:0]) : $signed(quo_reg[31:0]);

endmodule

>>> rtl/dhr_back.sv
// dhr_back: executes queued commands: tick decimation and averaging, ring
// storage, read walks and the result register. Uses dhr_pkg and dhr_divider.
`timescale 1ns / 1ps

module dhr_back
    import dhr_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    back_state_t        state_reg, state_next;
    logic [PW-1:0]      wp_reg, wp_next;
    logic [CW-1:0]      vc_reg, vc_next;
    logic [31:0]        seq_reg, seq_next;
    logic [31:0]        last_reg, last_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [15:0]        cnt_reg, cnt_next;

    logic signed [31:0] t_value_reg, t_value_next;
    logic [31:0]        t_now_reg, t_now_next;
    logic [31:0]        t_interval_reg, t_interval_next;
    logic               t_mode_reg, t_mode_next;

    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      rd_left_reg, rd_left_next;

    logic signed [31:0] ring_mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic               mem_we;
    logic signed [31:0] mem_wdata;
    logic               mem_re;

    logic               out_valid_reg;
    out_item_t          out_data_reg;
    logic               out_free;
    logic               out_load;
    out_item_t          out_load_data;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic               accumulate;
    logic signed [ACC_W-1:0] acc_upd;
    logic [15:0]        cnt_upd;
    logic               store_hit;
    logic               commit;
    logic signed [31:0] commit_value;

    logic [31:0]        unseen;
    logic [CW-1:0]      since_n;
    logic [CW:0]        wp_x;
    logic [CW:0]        n_x;
    logic [CW:0]        since_start;
    logic [CW-1:0]      read_n;
    logic [PW-1:0]      read_start;

    dhr_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Tick arithmetic on the latched tick.
    assign accumulate = t_mode_reg && (cnt_reg < COUNT_MAX);
    assign acc_upd    = accumulate ? acc_reg + ACC_W'(t_value_reg) : acc_reg;
    assign cnt_upd    = accumulate ? cnt_reg + 16'd1 : cnt_reg;
    assign store_hit  = ((t_now_reg - last_reg) >= t_interval_reg) || (seq_reg == '0);

    // Read run length and start for the command at the head of the queue.
    assign unseen      = seq_reg - cmd.seen_sequence;
    assign since_n     = (unseen < 32'(vc_reg)) ? unseen[CW-1:0] : vc_reg;
    assign wp_x        = (CW+1)'(wp_reg);
    assign n_x         = (CW+1)'(since_n);
    assign since_start = (wp_x >= n_x) ? wp_x - n_x : wp_x + (CW+1)'(DEPTH) - n_x;

    always_comb begin
        if (cmd.kind == CMD_READ_SINCE) begin
            read_n     = since_n;
            read_start = since_start[PW-1:0];
        end else begin
            read_n     = vc_reg;
            read_start = (vc_reg == CW'(DEPTH)) ? wp_reg : '0;
        end
    end

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        vc_next         = vc_reg;
        seq_next        = seq_reg;
        last_next       = last_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        t_value_next    = t_value_reg;
        t_now_next      = t_now_reg;
        t_interval_next = t_interval_reg;
        t_mode_next     = t_mode_reg;
        rd_ptr_next     = rd_ptr_reg;
        rd_left_next    = rd_left_reg;
        cmd_ready       = 1'b0;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = '0;
        out_load        = 1'b0;
        out_load_data   = '0;
        div_req         = '0;
        commit          = 1'b0;
        commit_value    = '0;

        unique case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    cmd_ready = 1'b1;
                    unique case (cmd.kind)
                        CMD_TICK: begin
                            t_value_next    = cmd.sample_value;
                            t_now_next      = cmd.now_us;
                            t_interval_next = cmd.interval_us;
                            t_mode_next     = cmd.average_mode;
                            state_next      = BK_TICK;
                        end
                        CMD_READ_ALL, CMD_READ_SINCE: begin
                            rd_ptr_next  = read_start;
                            rd_left_next = read_n;
                            state_next   = (read_n == '0) ? BK_EMPTY : BK_RD_REQ;
                        end
                        CMD_CLEAR: begin
                            wp_next   = '0;
                            vc_next   = '0;
                            seq_next  = '0;
                            last_next = '0;
                            acc_next  = '0;
                            cnt_next  = '0;
                        end
                    endcase
                end
            end
            BK_TICK: begin
                acc_next = acc_upd;
                cnt_next = cnt_upd;
                if (store_hit && t_mode_reg) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = acc_upd;
                    div_req.divisor  = cnt_upd;
                    acc_next         = '0;
                    cnt_next         = '0;
                    state_next       = BK_DIV;
                end else begin
                    commit       = store_hit;
                    commit_value = t_value_reg;
                    state_next   = BK_IDLE;
                end
            end
            BK_DIV: begin
                if (div_rsp.done) begin
                    commit       = 1'b1;
                    commit_value = div_rsp.quotient;
                    state_next   = BK_IDLE;
                end
            end
            BK_RD_REQ: begin
                mem_re     = 1'b1;
                state_next = BK_RD_PUSH;
            end
            BK_RD_PUSH: begin
                if (out_free) begin
                    out_load                       = 1'b1;
                    out_load_data.read_value       = rd_data_reg;
                    out_load_data.has_data         = 1'b1;
                    out_load_data.is_last          = rd_left_reg == CW'(1);
                    out_load_data.current_sequence = seq_reg;
                    out_load_data.stored_count     = 7'(vc_reg);
                    rd_left_next = rd_left_reg - 1'b1;
                    rd_ptr_next  = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                    state_next   = (rd_left_reg == CW'(1)) ? BK_IDLE : BK_RD_REQ;
                end
            end
            BK_EMPTY: begin
                if (out_free) begin
                    out_load                       = 1'b1;
                    out_load_data.read_value       = '0;
                    out_load_data.has_data         = 1'b0;
                    out_load_data.is_last          = 1'b1;
                    out_load_data.current_sequence = seq_reg;
                    out_load_data.stored_count     = 7'(vc_reg);
                    state_next                     = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        // Store one entry and advance the ring bookkeeping.
        if (commit) begin
            mem_we    = 1'b1;
            mem_wdata = commit_value;
            wp_next   = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (vc_reg != CW'(DEPTH)) begin
                vc_next = vc_reg + 1'b1;
            end
            // first store after reset, clear or wrap resyncs to the tick time
            last_next = (seq_reg == '0) ? t_now_reg : last_reg + t_interval_reg;
            seq_next  = seq_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            wp_reg    <= '0;
            vc_reg    <= '0;
            seq_reg   <= '0;
            last_reg  <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            vc_reg    <= vc_next;
            seq_reg   <= seq_next;
            last_reg  <= last_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_value_reg    <= t_value_next;
        t_now_reg      <= t_now_next;
        t_interval_reg <= t_interval_next;
        t_mode_reg     <= t_mode_next;
        rd_ptr_reg     <= rd_ptr_next;
        rd_left_reg    <= rd_left_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wp_reg] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= out_load_data;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vc_reg <= CW'(DEPTH))
        else $error("stored count above ring depth");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register loaded while a result is waiting");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == BK_DIV))
        else $error("divider finished outside the divide state");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_load_data.is_last) |=> (state_reg == BK_IDLE))
        else $error("read run continued after its last result");

    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == BK_TICK || state_reg == BK_DIV))
        else $error("ring written outside a tick");

endmodule

>>> rtl/decimating_history_ring_core.sv
// Decimating history ring: a ring of DEPTH signed 32-bit entries fed by ticks,
// with full and since-sequence read-out. A tick that stores no entry, or stores
// the latest sample, is latched and then run in the execution unit; a storing
// tick in average mode then waits on the 48-step bit-serial divider. A read of
// n entries passes each entry through the ring read port register and then
// the result register, stalling while a result is not taken; an empty read
// gives one result; a clear is done in the idle state. Items are queued in a
// two-entry command queue behind an input register, so up to three items can
// be taken while a read or an average is in progress. Configuration applies to
// items accepted after the write. Depends on dhr_pkg and the dhr_* modules.
`timescale 1ns / 1ps

module decimating_history_ring_core
    import dhr_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_payload,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_payload,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic queue_valid;
    logic queue_ready;
    cmd_t queue_cmd;

    dhr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    dhr_cmd_fifo u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_cmd)
    );

    dhr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule
